// ===== sv/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg
// Types and constants shared by the source byte tokenizer modules.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int OUT_POS_W = 32;
    localparam int INT_W     = 63;

    localparam logic [INT_W-1:0] INT_MAX63 = {INT_W{1'b1}};

    // token kinds
    localparam logic [3:0] K_IDENT    = 4'd0;
    localparam logic [3:0] K_INT      = 4'd1;
    localparam logic [3:0] K_COLON    = 4'd2;
    localparam logic [3:0] K_COLON_EQ = 4'd3;
    localparam logic [3:0] K_SEMI     = 4'd4;
    localparam logic [3:0] K_STAR     = 4'd5;
    localparam logic [3:0] K_EQUAL    = 4'd6;
    localparam logic [3:0] K_EOF      = 4'd7;
    localparam logic [3:0] K_ERROR    = 4'd8;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [3:0]           kind;
        logic [INT_W-1:0]     int_value;
        logic [OUT_POS_W-1:0] token_index;
        logic [OUT_POS_W-1:0] token_length;
        logic [OUT_POS_W-1:0] line;
        logic [OUT_POS_W-1:0] column;
        logic [OUT_POS_W-1:0] line_start_index;
        logic [7:0]           bad_char;
        logic                 last;
    } t_token;

    // tokens caused by one input byte or end marker
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_pair;

endpackage

// ===== sv/sbt_front.sv =====
// ----------------------------------------------------------------------------
// sbt_front
// Scanner: takes one byte or end marker per cycle while the queue has room,
// tracks position and pending token, and pushes completed tokens to the queue.
// ----------------------------------------------------------------------------
module sbt_front import sbt_pkg::*; #(
    parameter int POSITION_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_ch,
    input  logic       i_q_full,
    output logic       o_push,
    output t_pair      o_pair
);

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_ZERO = P'(0);
    localparam logic [P-1:0] POS_ONE  = P'(1);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_COLON  = 2'd3;

    logic [1:0]       r_mode, n_mode;
    logic [P-1:0]     r_cur_index, n_cur_index;
    logic [P-1:0]     r_cur_line, n_cur_line;
    logic [P-1:0]     r_cur_col, n_cur_col;
    logic [P-1:0]     r_cur_ls, n_cur_ls;
    logic [P-1:0]     r_tok_index, n_tok_index;
    logic [P-1:0]     r_tok_line, n_tok_line;
    logic [P-1:0]     r_tok_col, n_tok_col;
    logic [P-1:0]     r_tok_ls, n_tok_ls;
    logic [INT_W-1:0] r_acc, n_acc;

    logic             accept, is_byte;
    logic             is_ws, is_alpha, is_digit;
    logic             cont, coleq, mark;
    logic             p_valid, new_valid;
    logic [3:0]       p_kind, new_kind;
    logic [P-1:0]     p_len;
    logic [INT_W-1:0] p_val;
    logic [INT_W+3:0] acc_ext, acc_next;
    logic [7:0]       digit;
    t_token           p_tok, new_tok;

    function automatic t_token make_tok(
        input logic [3:0]       kind,
        input logic [INT_W-1:0] val,
        input logic [P-1:0]     idx,
        input logic [P-1:0]     len,
        input logic [P-1:0]     ln,
        input logic [P-1:0]     col,
        input logic [P-1:0]     ls,
        input logic [7:0]       bad
    );
        t_token t;
        t.kind             = kind;
        t.int_value        = val;
        t.token_index      = OUT_POS_W'(idx);
        t.token_length     = OUT_POS_W'(len);
        t.line             = OUT_POS_W'(ln);
        t.column           = OUT_POS_W'(col);
        t.line_start_index = OUT_POS_W'(ls);
        t.bad_char         = bad;
        t.last             = 1'b1;
        return t;
    endfunction

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        is_byte  = (i_op == OP_BYTE);
        is_ws    = (i_ch == CH_NL) || (i_ch == CH_BS) || (i_ch == CH_CR) || (i_ch == CH_SP);
        is_alpha = ((i_ch >= CH_LA) && (i_ch <= CH_LZ)) || ((i_ch >= CH_UA) && (i_ch <= CH_UZ));
        is_digit = (i_ch >= CH_0) && (i_ch <= CH_9);
        digit    = i_ch - CH_0;

        // saturating decimal accumulate, times ten as shift-add
        acc_ext  = (INT_W+4)'(r_acc);
        acc_next = (acc_ext << 3) + (acc_ext << 1) + (INT_W+4)'(digit);

        cont  = is_byte && (((r_mode == MODE_IDENT) && (is_alpha || is_digit)) ||
                            ((r_mode == MODE_NUMBER) && is_digit));
        coleq = is_byte && (r_mode == MODE_COLON) && (i_ch == CH_EQUAL);
        mark  = is_byte && !cont && !coleq && !is_ws;

        p_valid = (r_mode != MODE_IDLE) && !cont;
        case (r_mode)
            MODE_IDENT: begin
                p_kind = K_IDENT;
                p_len  = r_cur_index - r_tok_index;
            end
            MODE_NUMBER: begin
                p_kind = K_INT;
                p_len  = r_cur_index - r_tok_index;
            end
            MODE_COLON: begin
                p_kind = coleq ? K_COLON_EQ : K_COLON;
                p_len  = coleq ? P'(2) : POS_ONE;
            end
            default: begin
                p_kind = K_IDENT;
                p_len  = POS_ZERO;
            end
        endcase
        p_val = (r_mode == MODE_NUMBER) ? r_acc : '0;
        p_tok = make_tok(p_kind, p_val, r_tok_index, p_len, r_tok_line, r_tok_col,
                         r_tok_ls, 8'd0);

        new_valid = !is_byte || (mark && !is_alpha && !is_digit && (i_ch != CH_COLON));
        if (!is_byte)
            new_kind = K_EOF;
        else if (i_ch == CH_SEMI)
            new_kind = K_SEMI;
        else if (i_ch == CH_STAR)
            new_kind = K_STAR;
        else if (i_ch == CH_EQUAL)
            new_kind = K_EQUAL;
        else
            new_kind = K_ERROR;
        new_tok = make_tok(new_kind, '0, r_cur_index, is_byte ? POS_ONE : POS_ZERO,
                           r_cur_line, r_cur_col, r_cur_ls,
                           (new_kind == K_ERROR) ? i_ch : 8'd0);

        o_pair.two       = p_valid && new_valid;
        o_pair.tok0      = p_valid ? p_tok : new_tok;
        o_pair.tok0.last = !(p_valid && new_valid);
        o_pair.tok1      = new_tok;
        o_push           = accept && (p_valid || new_valid);

        n_mode      = r_mode;
        n_acc       = r_acc;
        n_tok_index = r_tok_index;
        n_tok_line  = r_tok_line;
        n_tok_col   = r_tok_col;
        n_tok_ls    = r_tok_ls;
        n_cur_index = r_cur_index;
        n_cur_line  = r_cur_line;
        n_cur_col   = r_cur_col;
        n_cur_ls    = r_cur_ls;

        if (accept) begin
            if (!is_byte) begin
                n_mode      = MODE_IDLE;
                n_acc       = '0;
                n_tok_index = POS_ZERO;
                n_tok_line  = POS_ONE;
                n_tok_col   = POS_ONE;
                n_tok_ls    = POS_ZERO;
                n_cur_index = POS_ZERO;
                n_cur_line  = POS_ONE;
                n_cur_col   = POS_ONE;
                n_cur_ls    = POS_ZERO;
            end else begin
                if (cont) begin
                    if (r_mode == MODE_NUMBER)
                        n_acc = (acc_next > (INT_W+4)'(INT_MAX63)) ? INT_MAX63
                                                                   : acc_next[INT_W-1:0];
                end else if (mark) begin
                    n_tok_index = r_cur_index;
                    n_tok_line  = r_cur_line;
                    n_tok_col   = r_cur_col;
                    n_tok_ls    = r_cur_ls;
                    if (is_alpha)
                        n_mode = MODE_IDENT;
                    else if (is_digit) begin
                        n_mode = MODE_NUMBER;
                        n_acc  = INT_W'(digit);
                    end else if (i_ch == CH_COLON)
                        n_mode = MODE_COLON;
                    else
                        n_mode = MODE_IDLE;
                end else begin
                    n_mode = MODE_IDLE;
                end

                if (i_ch == CH_NL) begin
                    n_cur_line = r_cur_line + POS_ONE;
                    n_cur_ls   = r_cur_index + POS_ONE;
                    n_cur_col  = POS_ONE;
                end else begin
                    n_cur_col  = r_cur_col + POS_ONE;
                end
                n_cur_index = r_cur_index + POS_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_acc       <= '0;
            r_tok_index <= POS_ZERO;
            r_tok_line  <= POS_ONE;
            r_tok_col   <= POS_ONE;
            r_tok_ls    <= POS_ZERO;
            r_cur_index <= POS_ZERO;
            r_cur_line  <= POS_ONE;
            r_cur_col   <= POS_ONE;
            r_cur_ls    <= POS_ZERO;
        end else begin
            r_mode      <= n_mode;
            r_acc       <= n_acc;
            r_tok_index <= n_tok_index;
            r_tok_line  <= n_tok_line;
            r_tok_col   <= n_tok_col;
            r_tok_ls    <= n_tok_ls;
            r_cur_index <= n_cur_index;
            r_cur_line  <= n_cur_line;
            r_cur_col   <= n_cur_col;
            r_cur_ls    <= n_cur_ls;
        end
    end

endmodule

// ===== sv/sbt_fifo.sv =====
// ----------------------------------------------------------------------------
// sbt_fifo
// Short register queue of token groups between scanner and output stage.
// ----------------------------------------------------------------------------
module sbt_fifo import sbt_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_pair o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_pair            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push)
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        if (do_pop)
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        if (do_push && !do_pop)
            n_count = r_count + CNT_W'(1);
        else if (do_pop && !do_push)
            n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== sv/sbt_back.sv =====
// ----------------------------------------------------------------------------
// sbt_back
// Output stage: unpacks token groups and drives one token per transfer.
// ----------------------------------------------------------------------------
module sbt_back import sbt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_pair        i_pair,
    output logic         o_pop,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [231:0] o_m_tdata,  // int_value, token_index, token_length, line,
                                     // column, line_start_index, bad_char, pad
    output logic [3:0]   o_m_tuser,  // kind
    output logic         o_m_tlast
);

    logic   r_out_valid, n_out_valid;
    logic   r_pend_valid, n_pend_valid;
    t_token r_out, n_out;
    t_token r_pend, n_pend;
    logic   load;

    always_comb begin
        load         = !r_out_valid || i_m_tready;
        o_pop        = load && !r_pend_valid && !i_empty;
        n_out_valid  = r_out_valid;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_pend       = r_pend;
        if (load) begin
            if (r_pend_valid) begin
                n_out        = r_pend;
                n_out_valid  = 1'b1;
                n_pend_valid = 1'b0;
            end else if (!i_empty) begin
                n_out        = i_pair.tok0;
                n_out_valid  = 1'b1;
                n_pend       = i_pair.tok1;
                n_pend_valid = i_pair.two;
            end else begin
                n_out_valid  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {1'b0, r_out.bad_char, r_out.line_start_index, r_out.column,
                         r_out.line, r_out.token_length, r_out.token_index,
                         r_out.int_value};

endmodule

// ===== sv/source_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming lexical tokenizer for source bytes.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle (tuser = 0) or an end marker (tuser = 1)
// and emits identifier, integer, ':', ':=', ';', '*', '=', end and error
// tokens, each with its start index, length, line, column and line start.
// A byte is accepted every cycle while the token queue has room; one byte
// yields zero, one or two tokens, and the output port drives one token per
// cycle while the receiver is ready, so bytes that close a pending token and
// start a one-byte token at once take two output transfers. A completed
// token is written to the queue and then registered in the output stage
// before it is presented. The queue holds FIFO_DEPTH byte results.
module source_byte_tokenizer import sbt_pkg::*; #(
    parameter int POSITION_BITS = 32,
    parameter int FIFO_DEPTH    = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // ch
    input  logic [0:0]   i_s_tuser,   // op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [231:0] o_m_tdata,   // int_value, token_index, token_length, line,
                                      // column, line_start_index, bad_char, pad
    output logic [3:0]   o_m_tuser,   // kind
    output logic         o_m_tlast
);

    logic  q_full, q_empty, q_push, q_pop;
    t_pair q_in, q_out;

    sbt_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_op       (i_s_tuser[0]),
        .i_ch       (i_s_tdata),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_pair     (q_in)
    );

    sbt_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    sbt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_pair     (q_out),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
